// File: src/pftd_pkg.sv
// shared constants and types for the trial-division prime filter
`default_nettype none

package pftd_pkg;

  localparam int unsigned NumberBits = 16;
  localparam int unsigned ValueBits  = 16;
  localparam int unsigned MaxItems   = 256;
  localparam int unsigned SlotBits   = 8;
  localparam int unsigned TotalBits  = 9;
  localparam int unsigned DivBits    = ValueBits / 2 + 1;
  localparam int unsigned DivBitsP1  = DivBits + 1;
  localparam int unsigned SqBits     = ValueBits + 1;
  localparam int unsigned BitIdxBits = $clog2(ValueBits);
  localparam int unsigned TrialStart = 2;

  typedef logic [ValueBits-1:0]  value_t;
  typedef logic [DivBits-1:0]    divisor_t;
  typedef logic [SqBits-1:0]     square_t;
  typedef logic [BitIdxBits-1:0] bit_idx_t;
  typedef logic [TotalBits-1:0]  total_t;
  typedef logic [SlotBits-1:0]   slot_t;

  typedef enum logic [1:0] {
    StIdle,
    StTrial,
    StDiv,
    StDone
  } state_e;

endpackage

`default_nettype wire

// File: src/pftd_in_if.sv
// input channel: number and list-end marker with valid/ready
`default_nettype none

interface pftd_in_if;
  logic                              valid;
  logic                              ready;
  logic [pftd_pkg::NumberBits-1:0]   number;
  logic                              last_item;

  modport source (output valid, output number, output last_item, input ready);
  modport sink   (input valid, input number, input last_item, output ready);
endinterface

`default_nettype wire

// File: src/pftd_out_if.sv
// output channel: tested number, keep flag, slot and running count with valid/ready
`default_nettype none

interface pftd_out_if;
  logic                             valid;
  logic                             ready;
  logic [pftd_pkg::NumberBits-1:0]  value_out;
  logic                             keep;
  logic [pftd_pkg::SlotBits-1:0]    slot_index;
  logic [pftd_pkg::TotalBits-1:0]   kept_total;
  logic                             list_end;

  modport source (output valid, output value_out, output keep, output slot_index,
                  output kept_total, output list_end, input ready);
  modport sink   (input valid, input value_out, input keep, input slot_index,
                  input kept_total, input list_end, output ready);
endinterface

`default_nettype wire

// File: src/prime_filter_trial_division.sv
// top level: prime filter by trial division on one shared restoring divider
//
// in_i carries a number and a last_item marker; out_o returns one result per
// number: the number, keep (set for a prime), its slot in the compacted list,
// the running count of kept primes and an echo of last_item. both channels
// transfer on a clock edge with valid and ready high.
// one number is worked on at a time: in_i.ready is high only while idle.
// divisors 2, 3, 5, 7, ... are tried while d*d <= n; each trial compares d*d
// with n in the trial state, then runs a restoring division one quotient bit
// per cycle on one subtractor. zero, one and numbers that arrive with the list
// full skip the trials and go straight to the done state.
// a 16-bit prime near 65535 tries 128 divisors.
// the result sits in an output register, so the next number is taken while
// a result still waits; a stalled out_o holds the finished item there and
// the block does not leave its done state until that register frees up.
// once 256 primes are kept, further primes are dropped. the count clears
// after the result of the item marked last is loaded.
// reset (rst_ni low, asynchronous) clears the count, the state and out_o.valid.
`default_nettype none

module prime_filter_trial_division (
  input  wire           clk_i,
  input  wire           rst_ni,
  pftd_in_if.sink       in_i,
  pftd_out_if.source    out_o
);

  pftd_pkg::state_e   state_q, state_d;
  pftd_pkg::value_t   n_q, n_d;
  logic               last_q, last_d;
  logic               prime_q, prime_d;
  pftd_pkg::divisor_t d_q, d_d;
  pftd_pkg::square_t  sq_q, sq_d;
  pftd_pkg::divisor_t rem_q, rem_d;
  pftd_pkg::bit_idx_t bit_q, bit_d;
  pftd_pkg::total_t   count_q, count_d;

  logic                             out_valid_q, out_valid_d;
  logic [pftd_pkg::NumberBits-1:0]  out_value_q, out_value_d;
  logic                             out_keep_q, out_keep_d;
  pftd_pkg::slot_t                  out_slot_q, out_slot_d;
  pftd_pkg::total_t                 out_total_q, out_total_d;
  logic                             out_end_q, out_end_d;

  logic                           full;
  logic                           keep;
  logic [pftd_pkg::DivBitsP1-1:0] trial;
  pftd_pkg::divisor_t             diff;
  logic                           ge;
  pftd_pkg::divisor_t             rem_next;
  pftd_pkg::value_t               n_in;
  logic                           load_out;

  assign full     = (count_q >= pftd_pkg::TotalBits'(pftd_pkg::MaxItems));
  assign keep     = prime_q & ~full;
  assign n_in     = in_i.number[pftd_pkg::ValueBits-1:0];

  // shared restoring divider step
  assign trial    = {rem_q, n_q[bit_q]};
  assign ge       = (trial >= {1'b0, d_q});
  assign diff     = trial[pftd_pkg::DivBits-1:0] - d_q;
  assign rem_next = ge ? diff : trial[pftd_pkg::DivBits-1:0];

  assign load_out = (state_q == pftd_pkg::StDone) && (!out_valid_q || out_o.ready);

  assign in_i.ready = (state_q == pftd_pkg::StIdle);

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    last_d  = last_q;
    prime_d = prime_q;
    d_d     = d_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    count_d = count_q;

    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_keep_d  = out_keep_q;
    out_slot_d  = out_slot_q;
    out_total_d = out_total_q;
    out_end_d   = out_end_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      pftd_pkg::StIdle: begin
        if (in_i.valid) begin
          n_d    = n_in;
          last_d = in_i.last_item;
          d_d    = pftd_pkg::DivBits'(pftd_pkg::TrialStart);
          sq_d   = pftd_pkg::SqBits'(pftd_pkg::TrialStart * pftd_pkg::TrialStart);
          if (full || n_in < pftd_pkg::ValueBits'(pftd_pkg::TrialStart)) begin
            prime_d = 1'b0;
            state_d = pftd_pkg::StDone;
          end else begin
            state_d = pftd_pkg::StTrial;
          end
        end
      end
      pftd_pkg::StTrial: begin
        if (sq_q > {1'b0, n_q}) begin
          prime_d = 1'b1;
          state_d = pftd_pkg::StDone;
        end else begin
          rem_d   = '0;
          bit_d   = pftd_pkg::BitIdxBits'(pftd_pkg::ValueBits - 1);
          state_d = pftd_pkg::StDiv;
        end
      end
      pftd_pkg::StDiv: begin
        rem_d = rem_next;
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          if (rem_next == '0) begin
            prime_d = 1'b0;
            state_d = pftd_pkg::StDone;
          end else begin
            // after two, odd divisors only: (d+2)^2 = d^2 + 4d + 4
            if (d_q == pftd_pkg::DivBits'(pftd_pkg::TrialStart)) begin
              d_d  = d_q + 1'b1;
              sq_d = sq_q + pftd_pkg::SqBits'(2 * pftd_pkg::TrialStart + 1);
            end else begin
              d_d  = d_q + pftd_pkg::DivBits'(2);
              sq_d = sq_q + pftd_pkg::SqBits'({d_q, 2'b00}) + pftd_pkg::SqBits'(4);
            end
            state_d = pftd_pkg::StTrial;
          end
        end
      end
      pftd_pkg::StDone: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          out_value_d = pftd_pkg::NumberBits'(n_q);
          out_keep_d  = keep;
          out_slot_d  = full ? pftd_pkg::SlotBits'(pftd_pkg::MaxItems - 1)
                             : count_q[pftd_pkg::SlotBits-1:0];
          out_total_d = count_q + pftd_pkg::TotalBits'(keep);
          out_end_d   = last_q;
          count_d     = last_q ? '0 : count_q + pftd_pkg::TotalBits'(keep);
          state_d     = pftd_pkg::StIdle;
        end
      end
      default: begin
        state_d = pftd_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pftd_pkg::StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    last_q      <= last_d;
    prime_q     <= prime_d;
    d_q         <= d_d;
    sq_q        <= sq_d;
    rem_q       <= rem_d;
    bit_q       <= bit_d;
    out_value_q <= out_value_d;
    out_keep_q  <= out_keep_d;
    out_slot_q  <= out_slot_d;
    out_total_q <= out_total_d;
    out_end_q   <= out_end_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.value_out  = out_value_q;
  assign out_o.keep       = out_keep_q;
  assign out_o.slot_index = out_slot_q;
  assign out_o.kept_total = out_total_q;
  assign out_o.list_end   = out_end_q;

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_total_q <= pftd_pkg::TotalBits'(pftd_pkg::MaxItems))
    else $error("kept_total above list capacity");

  a_keep_not_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_keep_q) |->
      out_value_q >= pftd_pkg::NumberBits'(pftd_pkg::TrialStart))
    else $error("zero or one kept as prime");

  a_slot_matches_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_keep_q) |->
      out_slot_q == pftd_pkg::SlotBits'(out_total_q - 1'b1))
    else $error("slot of kept item disagrees with count");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && out_end_q |-> count_q == '0)
    else $error("count not cleared after list end");

endmodule

`default_nettype wire

// File: verif/tb.sv
// testbench for the trial-division prime filter: directed table, a long list and random lists
`default_nettype none

module tb;

  typedef struct packed {
    pftd_pkg::value_t value_out;
    logic             keep;
    pftd_pkg::slot_t  slot_index;
    pftd_pkg::total_t kept_total;
    logic             list_end;
  } filter_result_t;

  typedef struct packed {
    pftd_pkg::value_t number;
    logic             last_item;
    logic             typed;
    filter_result_t   result;
  } stim_row_t;

  localparam int NumRows      = 21;
  localparam int TotalItems   = 1170;
  localparam int FillItems    = 340;
  localparam int SteadyFirst  = 600;
  localparam int SteadyLast   = 750;
  localparam int IdlePercent  = 37;
  localparam int DrainCycles  = 100;
  localparam int WatchdogLimit = 20000;

  // rows with typed=1 are checked against the values given here
  localparam stim_row_t DirectedRows [NumRows] = '{
    '{16'd0,     1'b0, 1'b1, '{16'd0,     1'b0, 8'd0, 9'd0, 1'b0}},
    '{16'd1,     1'b0, 1'b1, '{16'd1,     1'b0, 8'd0, 9'd0, 1'b0}},
    '{16'd2,     1'b0, 1'b1, '{16'd2,     1'b1, 8'd0, 9'd1, 1'b0}},
    '{16'd3,     1'b0, 1'b1, '{16'd3,     1'b1, 8'd1, 9'd2, 1'b0}},
    '{16'd4,     1'b0, 1'b1, '{16'd4,     1'b0, 8'd2, 9'd2, 1'b0}},
    '{16'd65535, 1'b0, 1'b1, '{16'd65535, 1'b0, 8'd2, 9'd2, 1'b0}},
    '{16'd65521, 1'b1, 1'b1, '{16'd65521, 1'b1, 8'd2, 9'd3, 1'b1}},
    '{16'd7,     1'b1, 1'b1, '{16'd7,     1'b1, 8'd0, 9'd1, 1'b1}},
    '{16'd0,     1'b1, 1'b1, '{16'd0,     1'b0, 8'd0, 9'd0, 1'b1}},
    '{16'd9,     1'b0, 1'b0, '0},
    '{16'd25,    1'b0, 1'b0, '0},
    '{16'd49,    1'b0, 1'b0, '0},
    '{16'd169,   1'b0, 1'b0, '0},
    '{16'd65025, 1'b0, 1'b0, '0},
    '{16'd32768, 1'b0, 1'b0, '0},
    '{16'd32749, 1'b0, 1'b0, '0},
    '{16'd5,     1'b0, 1'b0, '0},
    '{16'd65519, 1'b0, 1'b0, '0},
    '{16'd21845, 1'b0, 1'b0, '0},
    '{16'd43690, 1'b0, 1'b0, '0},
    '{16'd1,     1'b1, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  pftd_in_if  in_ch ();
  pftd_out_if out_ch ();

  prime_filter_trial_division dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  pftd_pkg::total_t kept_primes = '0;
  filter_result_t   expected_results [$];
  int               sent = 0;
  int               mismatches = 0;
  int               quiet_cycles = 0;

  function automatic bit prime_by_trial(pftd_pkg::value_t n);
    if (n < pftd_pkg::TrialStart) return 1'b0;
    for (int unsigned d = pftd_pkg::TrialStart; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic filter_result_t predict_filter(pftd_pkg::value_t n, logic last);
    filter_result_t r;
    bit full;
    full         = kept_primes >= pftd_pkg::total_t'(pftd_pkg::MaxItems);
    r.value_out  = n;
    r.slot_index = full ? pftd_pkg::slot_t'(pftd_pkg::MaxItems - 1)
                        : pftd_pkg::slot_t'(kept_primes);
    r.keep       = !full && prime_by_trial(n);
    if (r.keep) kept_primes = kept_primes + 1'b1;
    r.kept_total = kept_primes;
    r.list_end   = last;
    if (last) kept_primes = '0;
    return r;
  endfunction

  function automatic bit take_break();
    if (sent >= SteadyFirst && sent < SteadyLast) return 1'b0;
    return $urandom_range(99) < IdlePercent;
  endfunction

  function automatic pftd_pkg::value_t pick_small_prime();
    pftd_pkg::value_t n;
    do n = pftd_pkg::value_t'($urandom_range(1000, 2)); while (!prime_by_trial(n));
    return n;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_number(pftd_pkg::value_t n, logic last, logic typed,
                             filter_result_t typed_result);
    filter_result_t predicted;
    while (take_break()) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.number    = n;
    in_ch.last_item = last;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = predict_filter(n, last);
    expected_results.push_back(typed ? typed_result : predicted);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    int               len;
    pftd_pkg::value_t n;
    in_ch.valid     = 1'b0;
    in_ch.number    = '0;
    in_ch.last_item = 1'b0;
    out_ch.ready    = 1'b0;
    rst_ni          = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirectedRows[i]) begin
      send_number(DirectedRows[i].number, DirectedRows[i].last_item,
                  DirectedRows[i].typed, DirectedRows[i].result);
    end

    // one long list of mostly primes so the compacted list overflows
    for (int i = 0; i < FillItems; i++) begin
      n = ($urandom_range(99) < 88) ? pick_small_prime()
                                    : pftd_pkg::value_t'($urandom_range(1023));
      send_number(n, i == FillItems - 1, 1'b0, '0);
    end

    while (sent < TotalItems) begin
      len = $urandom_range(40, 1);
      for (int j = 0; j < len; j++) begin
        case ($urandom_range(9))
          0:       n = pftd_pkg::value_t'($urandom_range(65535));
          1:       n = pick_small_prime();
          2: begin
            case ($urandom_range(5))
              0:       n = '0;
              1:       n = pftd_pkg::value_t'(1);
              2:       n = pftd_pkg::value_t'(2);
              3:       n = pftd_pkg::value_t'(3);
              4:       n = '1;
              default: n = pftd_pkg::value_t'(65521);
            endcase
          end
          default: n = pftd_pkg::value_t'($urandom_range(1023));
        endcase
        send_number(n, j == len - 1, 1'b0, '0);
      end
    end

    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ch.ready = !take_break();
  end

  always @(posedge clk_i) begin
    filter_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual value %0d",
                 $time, out_ch.value_out);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("value_out",  want.value_out,  out_ch.value_out);
        check_field("keep",       want.keep,       out_ch.keep);
        check_field("slot_index", want.slot_index, out_ch.slot_index);
        check_field("kept_total", want.kept_total, out_ch.kept_total);
        check_field("list_end",   want.list_end,   out_ch.list_end);
      end
    end
  end

  // no transfer on either side for too long means the block hung
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire
